// ===== hw/rtl/srs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    localparam int WINDOW       = 4;
    localparam int SEQ_BITS     = 3;
    localparam int PAYLOAD_BITS = 64;
    localparam int MSG_BITS     = 64;
    localparam int CNT_BITS     = 3;
    localparam int IDX_BITS     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [CNT_BITS-1:0] WIN_COUNT = CNT_BITS'(WINDOW);

    localparam logic [1:0] MODE_SEND    = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [MSG_BITS-1:0] message_payload;
        logic [SEQ_BITS-1:0] ack_number;
        logic                ack_checksum_ok;
        logic [SEQ_BITS-1:0] expired_number;
    } srs_in_t;

    typedef struct packed {
        logic                send_accepted;
        logic                packet_valid;
        logic [SEQ_BITS-1:0] packet_seq;
        logic [MSG_BITS-1:0] packet_payload;
        timer_cmd_t          timer_cmd;
        logic [SEQ_BITS-1:0] timer_seq;
        logic                window_full;
        logic [CNT_BITS-1:0] in_flight;
    } srs_out_t;

    // window bookkeeping: slot i holds sequence number base + i
    typedef struct packed {
        logic [SEQ_BITS-1:0] base;
        logic [SEQ_BITS-1:0] next;
        logic [CNT_BITS-1:0] count;
        logic [WINDOW-1:0]   acked;
    } srs_ctrl_t;

    typedef logic [PAYLOAD_BITS-1:0] slot_word_t;
    typedef slot_word_t [WINDOW-1:0] slot_array_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srs_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srs_window (
    input  var srs_pkg::srs_in_t     in_i,
    input  var srs_pkg::srs_ctrl_t   ctrl_i,
    input  var srs_pkg::slot_array_t pay_i,
    output srs_pkg::srs_ctrl_t       ctrl_o,
    output srs_pkg::slot_array_t     pay_o,
    output srs_pkg::srs_out_t        res_o
);
    import srs_pkg::*;

    logic [SEQ_BITS-1:0] k_ack;
    logic [SEQ_BITS-1:0] k_exp;
    logic                ack_hit;
    logic                exp_hit;
    logic [WINDOW-1:0]   acked_m;
    logic [CNT_BITS-1:0] slide_n;
    logic [WINDOW-1:0]   acked_s;
    slot_array_t         pay_s;
    slot_word_t          new_word;

    assign k_ack    = in_i.ack_number - ctrl_i.base;
    assign k_exp    = in_i.expired_number - ctrl_i.base;
    assign ack_hit  = in_i.ack_checksum_ok && (k_ack < ctrl_i.count);
    assign exp_hit  = k_exp < ctrl_i.count;
    assign new_word = in_i.message_payload[PAYLOAD_BITS-1:0];

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            acked_m[i] = ctrl_i.acked[i] | (ack_hit && (k_ack == SEQ_BITS'(i)));
        end
    end

    // leading acknowledged slots
    always_comb begin
        logic run;
        run     = 1'b1;
        slide_n = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (run && (CNT_BITS'(i) < ctrl_i.count) && acked_m[i]) begin
                slide_n = slide_n + 1'b1;
            end else begin
                run = 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            acked_s[i] = 1'b0;
            pay_s[i]   = pay_i[i];
            for (int j = 0; j <= WINDOW; j++) begin
                if ((slide_n == CNT_BITS'(j)) && (i + j < WINDOW)) begin
                    acked_s[i] = acked_m[(i + j) % WINDOW];
                    pay_s[i]   = pay_i[(i + j) % WINDOW];
                end
            end
        end
    end

    always_comb begin
        ctrl_o = ctrl_i;
        pay_o  = pay_i;
        res_o  = '0;
        case (in_i.mode)
            MODE_SEND: begin
                if (ctrl_i.count < WIN_COUNT) begin
                    for (int i = 0; i < WINDOW; i++) begin
                        if (ctrl_i.count == CNT_BITS'(i)) begin
                            ctrl_o.acked[i] = 1'b0;
                            pay_o[i]        = new_word;
                        end
                    end
                    res_o.send_accepted  = 1'b1;
                    res_o.packet_valid   = 1'b1;
                    res_o.packet_seq     = ctrl_i.next;
                    res_o.packet_payload = MSG_BITS'(new_word);
                    res_o.timer_cmd      = TMR_START;
                    res_o.timer_seq      = ctrl_i.next;
                    ctrl_o.next          = ctrl_i.next + 1'b1;
                    ctrl_o.count         = ctrl_i.count + 1'b1;
                end
            end
            MODE_ACK: begin
                if (ack_hit) begin
                    ctrl_o.acked = acked_m;
                    if (in_i.ack_number == ctrl_i.base) begin
                        ctrl_o.acked = acked_s;
                        pay_o        = pay_s;
                        ctrl_o.base  = ctrl_i.base + SEQ_BITS'(slide_n);
                        ctrl_o.count = ctrl_i.count - slide_n;
                    end
                    res_o.timer_cmd = TMR_STOP;
                    res_o.timer_seq = in_i.ack_number;
                end
            end
            MODE_TIMEOUT: begin
                if (exp_hit) begin
                    res_o.packet_valid   = 1'b1;
                    res_o.packet_seq     = in_i.expired_number;
                    res_o.packet_payload = MSG_BITS'(pay_i[k_exp[IDX_BITS-1:0]]);
                    res_o.timer_cmd      = TMR_RESTART;
                    res_o.timer_seq      = in_i.expired_number;
                end
            end
            default: begin
            end
        endcase
        res_o.window_full = (ctrl_o.count == WIN_COUNT);
        res_o.in_flight   = ctrl_o.count;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/selective_repeat_sender.sv =====
// selective repeat sender, four-slot window, 3-bit sequence numbers
// s_ channel: one event per transaction (send, acknowledgment or timer expiry)
// m_ channel: exactly one result per accepted event: packet to emit, timer
//   command, window_full and in_flight after the event
// the result is registered and presented in the cycle after the event is accepted
// throughput: one event per cycle while the receiver takes results; the window
//   state update is combinational logic from the state registers back into
//   themselves, and the result sits in an output register
// s_ready is high while the output register is empty or being taken, so a
//   new event is accepted in the same cycle a waiting result leaves
// receiver stall: the result holds in the output register, s_ready drops
//   and no event is lost or repeated
// reset (aresetn low, synchronous): window empty, base and next sequence
//   numbers zero, no result pending; stored payloads are not cleared
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  var srs_pkg::srs_in_t s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output srs_pkg::srs_out_t    m_data
);
    import srs_pkg::*;

    srs_ctrl_t   ctrl_reg;
    srs_ctrl_t   ctrl_next;
    slot_array_t pay_reg;
    slot_array_t pay_next;
    srs_out_t    res_next;
    srs_out_t    m_data_reg;
    logic        m_valid_reg;
    logic        accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    srs_window u_window (
        .in_i   (s_data),
        .ctrl_i (ctrl_reg),
        .pay_i  (pay_reg),
        .ctrl_o (ctrl_next),
        .pay_o  (pay_next),
        .res_o  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ctrl_reg <= ctrl_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pay_reg    <= pay_next;
            m_data_reg <= res_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.count <= WIN_COUNT)
        else $error("window occupancy above window size");

    a_seq_span: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.next == SEQ_BITS'(ctrl_reg.base + ctrl_reg.count))
        else $error("next sequence number out of step with base and count");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window_full == (m_data.in_flight == WIN_COUNT)))
        else $error("window_full disagrees with in_flight");

    a_send_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.send_accepted) |->
            (m_data.packet_valid && (m_data.timer_cmd == TMR_START)))
        else $error("accepted send without packet and timer start");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_selective_repeat_sender.sv =====
`timescale 1ns / 1ps

module tb_selective_repeat_sender;

    import srs_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    srs_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    srs_out_t m_data;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    logic long_hold = 1'b0;
    int mismatches = 0;
    event hold_trigger;

    // window state mirrored by the predictor
    logic [SEQ_BITS-1:0]     win_base;
    logic [SEQ_BITS-1:0]     win_next;
    logic [CNT_BITS-1:0]     win_count;
    logic [WINDOW-1:0]       win_acked;
    logic [MSG_BITS-1:0]     win_payload [WINDOW];

    srs_out_t pending_results [$];

    selective_repeat_sender u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic srs_out_t predict_window(srs_in_t ev);
        srs_out_t r;
        logic [SEQ_BITS-1:0] off;
        int n;
        r = '0;
        case (ev.mode)
            MODE_SEND: begin
                if (win_count < WINDOW) begin
                    win_payload[win_count] = ev.message_payload;
                    win_acked[win_count] = 1'b0;
                    r.send_accepted = 1'b1;
                    r.packet_valid = 1'b1;
                    r.packet_seq = win_next;
                    r.packet_payload = ev.message_payload;
                    r.timer_cmd = TMR_START;
                    r.timer_seq = win_next;
                    win_next = win_next + 1'b1;
                    win_count = win_count + 1'b1;
                end
            end
            MODE_ACK: begin
                off = ev.ack_number - win_base;
                if (ev.ack_checksum_ok && off < win_count) begin
                    win_acked[off] = 1'b1;
                    if (ev.ack_number == win_base) begin
                        n = 0;
                        while (n < win_count && win_acked[n]) n++;
                        for (int i = 0; i < WINDOW; i++) begin
                            if (i + n < WINDOW) begin
                                win_payload[i] = win_payload[i + n];
                                win_acked[i] = win_acked[i + n];
                            end else begin
                                win_acked[i] = 1'b0;
                            end
                        end
                        win_base = win_base + SEQ_BITS'(n);
                        win_count = win_count - CNT_BITS'(n);
                    end
                    r.timer_cmd = TMR_STOP;
                    r.timer_seq = ev.ack_number;
                end
            end
            MODE_TIMEOUT: begin
                off = ev.expired_number - win_base;
                if (off < win_count) begin
                    r.packet_valid = 1'b1;
                    r.packet_seq = ev.expired_number;
                    r.packet_payload = win_payload[off];
                    r.timer_cmd = TMR_RESTART;
                    r.timer_seq = ev.expired_number;
                end
            end
            default: begin
            end
        endcase
        r.window_full = (win_count >= WINDOW);
        r.in_flight = win_count;
        return r;
    endfunction

    function automatic srs_in_t make_item(logic [1:0] mode, logic [MSG_BITS-1:0] payload,
                                          logic [SEQ_BITS-1:0] num, logic ok);
        srs_in_t ev;
        ev.mode = mode;
        ev.message_payload = payload;
        ev.ack_number = num;
        ev.ack_checksum_ok = ok;
        ev.expired_number = num;
        return ev;
    endfunction

    // mostly well-formed traffic aimed at the current window, some noise
    function automatic srs_in_t random_item();
        srs_in_t ev;
        int pick;
        ev.mode = 2'($urandom_range(3));
        ev.message_payload = {$urandom, $urandom};
        ev.ack_number = 3'($urandom);
        ev.ack_checksum_ok = 1'($urandom);
        ev.expired_number = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            ev.mode = MODE_SEND;
        end else if (pick < 72) begin
            ev.mode = MODE_ACK;
            ev.ack_checksum_ok = 1'b1;
            if (win_count != 0) begin
                if ($urandom_range(1) == 0)
                    ev.ack_number = win_base;
                else
                    ev.ack_number = win_base + 3'($urandom_range(win_count - 1));
            end
        end else if (pick < 87) begin
            ev.mode = MODE_TIMEOUT;
            if (win_count != 0)
                ev.expired_number = win_base + 3'($urandom_range(win_count - 1));
        end
        return ev;
    endfunction

    task automatic send_event(srs_in_t ev);
        int gap;
        gap = 0;
        while (gap < 50 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= ev;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_window(ev));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        srs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none actual %p", $time, m_data);
            end else begin
                want = pending_results.pop_front();
                report_field("send_accepted", want.send_accepted, m_data.send_accepted);
                report_field("packet_valid", want.packet_valid, m_data.packet_valid);
                report_field("packet_seq", want.packet_seq, m_data.packet_seq);
                report_field("packet_payload", want.packet_payload, m_data.packet_payload);
                report_field("timer_cmd", want.timer_cmd, m_data.timer_cmd);
                report_field("timer_seq", want.timer_seq, m_data.timer_seq);
                report_field("window_full", want.window_full, m_data.window_full);
                report_field("in_flight", want.in_flight, m_data.in_flight);
            end
        end
    end

    always @(posedge aclk) begin
        if (long_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off
    initial begin
        forever begin
            @(hold_trigger);
            @(posedge aclk);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            long_hold <= 1'b0;
        end
    end

    task automatic test_fill_and_refuse();
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        send_event(make_item(MODE_SEND, 64'h0, 3'd0, 1'b0));
        send_event(make_item(MODE_SEND, '1, 3'd7, 1'b1));
        send_event(make_item(MODE_SEND, {$urandom, $urandom}, 3'd0, 1'b0));
        send_event(make_item(MODE_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0));
        send_event(make_item(MODE_SEND, 64'h5555_aaaa_5555_aaaa, 3'd0, 1'b0));
        send_event(make_item(MODE_TIMEOUT, 64'h0, 3'd2, 1'b0));
        send_event(make_item(MODE_TIMEOUT, 64'h0, 3'd5, 1'b0));
        drain();
    endtask

    task automatic test_ack_handling();
        send_event(make_item(MODE_ACK, 64'h0, 3'd1, 1'b0));
        send_event(make_item(MODE_ACK, 64'h0, 3'd6, 1'b1));
        send_event(make_item(MODE_ACK, 64'h0, 3'd2, 1'b1));
        send_event(make_item(MODE_ACK, 64'h0, 3'd2, 1'b1));
        send_event(make_item(MODE_ACK, 64'h0, 3'd0, 1'b1));
        send_event(make_item(MODE_ACK, 64'h0, 3'd1, 1'b1));
        send_event(make_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0));
        send_event(make_item(MODE_ACK, 64'h0, 3'd3, 1'b1));
        drain();
    endtask

    task automatic test_wrap_and_unknown();
        for (int i = 0; i < 4; i++)
            send_event(make_item(MODE_SEND, {$urandom, $urandom}, 3'd0, 1'b0));
        send_event(make_item(MODE_ACK, 64'h0, 3'd7, 1'b1));
        send_event(make_item(MODE_ACK, 64'h0, 3'd4, 1'b1));
        send_event(make_item(MODE_SEND, {$urandom, $urandom}, 3'd0, 1'b0));
        send_event(make_item(MODE_TIMEOUT, 64'h0, 3'd0, 1'b0));
        send_event(make_item(MODE_UNUSED, '1, 3'd7, 1'b1));
        drain();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_event(random_item());
        drain();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        -> hold_trigger;
        for (int i = 0; i < 40; i++)
            send_event(random_item());
        drain();
    endtask

    initial begin
        win_base = '0;
        win_next = '0;
        win_count = '0;
        win_acked = '0;
        foreach (win_payload[i]) win_payload[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_fill_and_refuse();
        test_ack_handling();
        test_wrap_and_unknown();
        test_random_traffic(0, 0, 500);
        test_random_traffic(61, 0, 500);
        test_random_traffic(0, 61, 500);
        test_random_traffic(20, 20, 500);
        test_backpressure();
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d transactions never arrived", $time, pending_results.size());
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
